[sv/ntcb_pkg.sv]
// ntcb_pkg: shared types and constants for the NTC Beta-equation temperature block.
// Used by ntcb_log2, ntcb_div and ntc_thermistor_beta_temperature.
package ntcb_pkg;

  localparam int DIV_W = 48;
  localparam int LOG_W = 29;

  localparam logic [31:0]      LN2_Q32     = 32'd2977044472;
  localparam logic [DIV_W-1:0] HUNDRED_Q40 = 48'd109951162777600;
  localparam logic [16:0]      ABS_ZERO_CC = 17'd27315;
  localparam logic [16:0]      TEMP_MAX_CC = 17'd50000;
  localparam logic [DIV_W-1:0] TCK_LIMIT   = 48'd77315;

  localparam logic [2:0] REG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_FULLSCALE = 3'd1;
  localparam logic [2:0] REG_VREF      = 3'd2;
  localparam logic [2:0] REG_RPULL     = 3'd3;
  localparam logic [2:0] REG_RNOM      = 3'd4;
  localparam logic [2:0] REG_BETA      = 3'd5;
  localparam logic [2:0] REG_T0        = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VDIV, ST_VWAIT, ST_LOG, ST_LWAIT, ST_MUL, ST_TDIV, ST_TWAIT,
    ST_IDIV, ST_IWAIT, ST_CHECK, ST_RDIV, ST_RWAIT, ST_OUT
  } state_t;

endpackage

[sv/ntcb_log2.sv]
// ntcb_log2: iterative log2 in Q5.24, one mantissa squaring per cycle.
// Depends on ntcb_pkg.
module ntcb_log2
  import ntcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [19:0]      n,
  output logic             done,
  output logic [LOG_W-1:0] result
);

  logic [4:0]  k_in;
  logic [4:0]  k;
  logic [30:0] m;
  logic [23:0] frac;
  logic [4:0]  cnt;
  logic        busy;
  logic [61:0] sq;
  logic [31:0] sq_hi;

  always_comb begin
    k_in = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (n[i]) k_in = 5'(i);
    end
  end

  assign sq     = 62'(m) * 62'(m);
  assign sq_hi  = sq[61:30];
  assign result = {k, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        k    <= k_in;
        frac <= 24'd0;
        m    <= 31'({11'd0, n} << (5'd30 - k_in));
      end else if (busy) begin
        if (sq_hi[31]) begin
          m    <= sq_hi[31:1];
          frac <= {frac[22:0], 1'b1};
        end else begin
          m    <= sq_hi[30:0];
          frac <= {frac[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/ntcb_div.sv]
// ntcb_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on ntcb_pkg.
module ntcb_div
  import ntcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] r;
  logic [DIV_W-1:0] d;
  logic [5:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  assign trial = {r, quo[DIV_W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        r    <= '0;
        quo  <= num;
        d    <= den;
      end else if (busy) begin
        if (!trial[DIV_W]) r <= trial[DIV_W-1:0];
        else r <= {r[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], ~trial[DIV_W]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/ntc_thermistor_beta_temperature.sv]
// ntc_thermistor_beta_temperature: NTC thermistor temperature by the Beta equation.
// Sequencer around one shared log2 unit (ntcb_log2) and one divider (ntcb_div).
//
//   channel | signals                         | item
//   s_      | s_tvalid s_tready s_tdata       | tick with adc_value
//   m_      | m_tvalid m_tready m_tdata       | adc_used, voltage_mv, temp_centi_celsius
//   cfg_    | cfg_valid cfg_ready cfg_index/data | register write
//
// A tick that emits nothing only advances the tick count. An emitting tick runs four
// divisions (launch, 48 quotient bits, done) and four logarithms, plus the accept,
// multiply, check and output steps. A negative or zero reciprocal skips the last
// division; a degenerate setting ends after the voltage division. Reset clears the
// tick count and loads the register defaults.
// s_tready is low from an emitting tick until its result enters the output register;
// a full output register holds the sequencer in its last state until m_tready.
module ntc_thermistor_beta_temperature
  import ntcb_pkg::*;
#(
  parameter int ADC_BITS = 12,
  localparam int IW = ((ADC_BITS + 7) / 8) * 8,
  localparam int OW = ((ADC_BITS + 37) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [IW-1:0] s_tdata,   // adc_value
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [OW-1:0] m_tdata,   // adc_used, voltage_mv[12:0], temp_centi_celsius[16:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [19:0]   cfg_data
);

  state_t state, state_next;

  logic [15:0] r_interval, r_fs, r_t0;
  logic [12:0] r_vref;
  logic [19:0] r_rpull, r_rnom;
  logic [13:0] r_beta;
  logic [15:0] tick_count;

  logic [ADC_BITS-1:0] a_reg;
  logic [15:0]         fs_reg;
  logic [12:0]         volt;
  logic signed [16:0]  temp;
  logic signed [31:0]  s_acc;
  logic [1:0]          idx;
  logic [61:0]         prod;
  logic [DIV_W-1:0]    term, inv0, inv_reg;
  logic signed [49:0]  inv;
  logic [ADC_BITS-1:0] out_a;
  logic [12:0]         out_v;
  logic signed [16:0]  out_t;

  logic             in_acc, deg;
  logic [15:0]      cnt_inc, fs_c, a_c1, a_c2, a_ext;
  logic [28:0]      av;
  logic [29:0]      mag;
  logic             log_start, log_done, div_start, div_done;
  logic [19:0]      log_n;
  logic [LOG_W-1:0] log_res;
  logic [DIV_W-1:0] div_num, div_den, quo;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign cnt_inc   = tick_count + 16'd1;
  assign fs_c      = (r_fs < 16'd2) ? 16'd2 : r_fs;
  assign a_ext     = 16'(s_tdata[ADC_BITS-1:0]);
  assign a_c1      = (a_ext > fs_c - 16'd1) ? fs_c - 16'd1 : a_ext;
  assign a_c2      = (a_c1 == 16'd0) ? 16'd1 : a_c1;
  assign deg       = (r_rpull == 20'd0) || (r_rnom == 20'd0) || (r_beta == 14'd0) ||
                     (r_t0 == 16'd0);
  assign av        = 29'(a_reg) * 29'(r_vref);
  assign mag       = s_acc[31] ? 30'(-s_acc) : 30'(s_acc);
  assign inv       = s_acc[31] ? ({2'b0, inv0} - {2'b0, term}) : ({2'b0, inv0} + {2'b0, term});
  assign m_tdata   = OW'({out_t, out_v, out_a});

  always_ff @(posedge clk) begin
    if (rst) begin
      r_interval <= 16'd1;
      r_fs       <= 16'd4095;
      r_vref     <= 13'd3300;
      r_rpull    <= 20'd10000;
      r_rnom     <= 20'd10000;
      r_beta     <= 14'd3950;
      r_t0       <= 16'd29815;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTERVAL:  r_interval <= cfg_data[15:0];
        REG_FULLSCALE: r_fs       <= cfg_data[15:0];
        REG_VREF:      r_vref     <= cfg_data[12:0];
        REG_RPULL:     r_rpull    <= cfg_data;
        REG_RNOM:      r_rnom     <= cfg_data;
        REG_BETA:      r_beta     <= cfg_data[13:0];
        REG_T0:        r_t0       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    log_start  = 1'b0;
    div_start  = 1'b0;
    log_n      = r_rpull;
    div_num    = '0;
    div_den    = '0;
    unique case (idx)
      2'd0: log_n = r_rpull;
      2'd1: log_n = 20'(fs_reg - 16'(a_reg));
      2'd2: log_n = 20'(a_reg);
      2'd3: log_n = r_rnom;
      default: ;
    endcase
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_acc && !(cnt_inc < r_interval)) state_next = ST_VDIV;
      end
      ST_VDIV: begin
        div_start  = 1'b1;
        div_num    = DIV_W'(av) + DIV_W'(fs_reg[15:1]);
        div_den    = DIV_W'(fs_reg);
        state_next = ST_VWAIT;
      end
      ST_VWAIT: if (div_done) state_next = deg ? ST_OUT : ST_LOG;
      ST_LOG: begin
        log_start  = 1'b1;
        state_next = ST_LWAIT;
      end
      ST_LWAIT: if (log_done) state_next = (idx == 2'd3) ? ST_MUL : ST_LOG;
      ST_MUL: state_next = ST_TDIV;
      ST_TDIV: begin
        div_start  = 1'b1;
        div_num    = DIV_W'(prod[61:16]);
        div_den    = DIV_W'(r_beta);
        state_next = ST_TWAIT;
      end
      ST_TWAIT: if (div_done) state_next = ST_IDIV;
      ST_IDIV: begin
        div_start  = 1'b1;
        div_num    = HUNDRED_Q40 + DIV_W'(r_t0[15:1]);
        div_den    = DIV_W'(r_t0);
        state_next = ST_IWAIT;
      end
      ST_IWAIT: if (div_done) state_next = ST_CHECK;
      ST_CHECK: state_next = (inv[49] || inv == 50'sd0) ? ST_OUT : ST_RDIV;
      ST_RDIV: begin
        div_start  = 1'b1;
        div_num    = HUNDRED_Q40 + {1'b0, inv_reg[DIV_W-1:1]};
        div_den    = inv_reg;
        state_next = ST_RWAIT;
      end
      ST_RWAIT: if (div_done) state_next = ST_OUT;
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 16'd0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_acc) begin
          if (cnt_inc < r_interval) tick_count <= cnt_inc;
          else begin
            tick_count <= 16'd0;
            a_reg      <= a_c2[ADC_BITS-1:0];
            fs_reg     <= fs_c;
            s_acc      <= 32'sd0;
            idx        <= 2'd0;
          end
        end
        ST_VWAIT: if (div_done) begin
          volt <= quo[12:0];
          if (deg) temp <= -$signed(ABS_ZERO_CC);
        end
        ST_LWAIT: if (log_done) begin
          if (idx[1]) s_acc <= s_acc - $signed(32'(log_res));
          else s_acc <= s_acc + $signed(32'(log_res));
          idx <= idx + 2'd1;
        end
        ST_MUL: prod <= 62'(mag) * 62'(LN2_Q32);
        ST_TWAIT: if (div_done) term <= quo;
        ST_IWAIT: if (div_done) inv0 <= quo;
        ST_CHECK: begin
          inv_reg <= inv[DIV_W-1:0];
          if (inv[49]) temp <= -$signed(ABS_ZERO_CC);
          else if (inv == 50'sd0) temp <= $signed(TEMP_MAX_CC);
        end
        ST_RWAIT: if (div_done) begin
          if (quo >= TCK_LIMIT) temp <= $signed(TEMP_MAX_CC);
          else temp <= $signed(quo[16:0] - ABS_ZERO_CC);
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          out_a    <= a_reg;
          out_v    <= volt;
          out_t    <= temp;
        end
        default: ;
      endcase
    end
  end

  ntcb_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .n      (log_n),
    .done   (log_done),
    .result (log_res)
  );

  ntcb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_t >= -$signed(ABS_ZERO_CC)) && (out_t <= $signed(TEMP_MAX_CC)))
    else $error("temperature out of range");

  a_adc_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_a != '0)
    else $error("clamped reading is zero");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(log_start && div_start))
    else $error("two units launched at once");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && state_next == ST_VDIV) |=> tick_count == 16'd0)
    else $error("tick count not cleared on emit");

endmodule

[tb/tb_ntc_thermistor_beta_temperature.sv]
// Testbench for ntc_thermistor_beta_temperature: random and directed ticks with readings,
// register settings between phases, results checked against an in-bench Beta-equation model.
// Depends on ntcb_pkg and the block RTL.
`timescale 1ns / 100ps

class ntc_temp_scoreboard;
  logic [31:0] interval, full_scale, vref_mv, rpull, rnom, beta, t0_ck;
  logic [15:0] ticks;
  logic [11:0] exp_adc[$];
  logic [12:0] exp_mv[$];
  logic [16:0] exp_temp[$];
  int mismatches;
  int results_seen;

  function void reset_state();
    interval = 1; full_scale = 4095; vref_mv = 3300; rpull = 10000;
    rnom = 10000; beta = 3950; t0_ck = 29815; ticks = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [19:0] val);
    case (idx)
      ntcb_pkg::REG_INTERVAL:  interval = val[15:0];
      ntcb_pkg::REG_FULLSCALE: full_scale = val[15:0];
      ntcb_pkg::REG_VREF:      vref_mv = val[12:0];
      ntcb_pkg::REG_RPULL:     rpull = val;
      ntcb_pkg::REG_RNOM:      rnom = val;
      ntcb_pkg::REG_BETA:      beta = val[13:0];
      ntcb_pkg::REG_T0:        t0_ck = val[15:0];
      default: ;
    endcase
  endfunction

  function longint log2_q24(longint unsigned n);
    int k;
    longint unsigned t, m, frac;
    k = 0; t = n; frac = 0;
    while (t > 1) begin
      t >>= 1;
      k++;
    end
    m = n << (30 - k);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(k) << 24) | longint'(frac);
  endfunction

  function longint centi_celsius(longint unsigned a, longint unsigned fs);
    longint s, inv;
    longint unsigned mag, term, inv0, tck, hq;
    hq = 64'd100 << 40;
    if (rpull == 0 || rnom == 0 || beta == 0 || t0_ck == 0) return -27315;
    s = log2_q24(rpull) + log2_q24(fs - a) - log2_q24(a) - log2_q24(rnom);
    mag = (s < 0) ? -s : s;
    term = ((mag * 64'd2977044472) >> 16) / beta;
    inv0 = (hq + t0_ck / 2) / t0_ck;
    inv = (s < 0) ? longint'(inv0) - longint'(term) : longint'(inv0) + longint'(term);
    if (inv < 0) return -27315;
    if (inv == 0) return 50000;
    tck = (hq + longint'(inv) / 2) / longint'(inv);
    if (tck >= 77315) return 50000;
    return longint'(tck) - 27315;
  endfunction

  function void note_tick(logic [11:0] adc);
    longint unsigned a, fs;
    ticks = ticks + 1;
    if (ticks < interval) return;
    ticks = 0;
    a = adc;
    fs = (full_scale < 2) ? 2 : full_scale;
    if (a > fs - 1) a = fs - 1;
    if (a < 1) a = 1;
    exp_adc.push_back(a[11:0]);
    exp_mv.push_back(13'((a * vref_mv + fs / 2) / fs));
    exp_temp.push_back(17'(centi_celsius(a, fs)));
  endfunction

  function void check_result(logic [11:0] adc, logic [12:0] mv, logic [16:0] temp);
    logic [11:0] ea;
    logic [12:0] em;
    logic [16:0] et;
    results_seen++;
    if (exp_adc.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result adc=%0d mv=%0d t=%0d", adc, mv,
                                     $signed(temp));
      return;
    end
    ea = exp_adc.pop_front(); em = exp_mv.pop_front(); et = exp_temp.pop_front();
    if (ea !== adc || em !== mv || et !== temp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp adc=%0d mv=%0d t=%0d, got adc=%0d mv=%0d t=%0d",
                 ea, em, $signed(et), adc, mv, $signed(temp));
    end
  endfunction
endclass

module tb_ntc_thermistor_beta_temperature;
  import ntcb_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = 0;   // adc_value
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;       // adc_used, voltage_mv, temp_centi_celsius
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [19:0] cfg_data = 0;

  ntc_temp_scoreboard board;
  int  cycles = 0;
  bit  calm = 0;
  bit  hold_off = 0;
  int  ticks_sent = 0;

  ntc_thermistor_beta_temperature dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata[11:0], m_tdata[24:12], m_tdata[41:25]);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        m_tready <= 0;
        repeat (gap) @(posedge clk);
        m_tready <= 1;
      end else m_tready <= 1;
    end
  end

  task automatic send_tick(logic [11:0] adc);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'b0, adc};
    do @(posedge clk); while (!s_tready);
    board.note_tick(adc);
    ticks_sent++;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [19:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.exp_adc.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [11:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: v = 12'd0;
        1: v = 12'hFFF;
        2: v = 12'($urandom_range(1, 8));
        default: v = 12'($urandom_range(0, 4095));
      endcase
      send_tick(v);
    end
  endtask

  initial begin
    logic [11:0] corner[$] = '{0, 1, 2, 12'hFFF, 4094, 4093, 2048, 2047, 12'hAAA, 12'h555};
    board = new();
    board.reset_state();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (corner[i]) send_tick(corner[i]);
    drain();

    // hold the output while ticks keep coming
    hold_off = 1;
    fork
      random_ticks(6);
      begin repeat (2000) @(posedge clk); hold_off = 0; end
    join
    drain();

    // extreme settings
    write_cfg(REG_INTERVAL, 0);
    write_cfg(REG_FULLSCALE, 255);
    write_cfg(REG_VREF, 5000);
    write_cfg(REG_RPULL, 1000000);
    write_cfg(REG_RNOM, 100);
    write_cfg(REG_BETA, 10000);
    write_cfg(REG_T0, 40000);
    foreach (corner[i]) send_tick(corner[i]);
    random_ticks(100);
    drain();

    write_cfg(REG_FULLSCALE, 65535);
    write_cfg(REG_VREF, 1000);
    write_cfg(REG_RPULL, 100);
    write_cfg(REG_RNOM, 1000000);
    write_cfg(REG_BETA, 1000);
    write_cfg(REG_T0, 20000);
    random_ticks(150);
    drain();

    // degenerate values and full scale below two
    write_cfg(REG_FULLSCALE, 1);
    write_cfg(REG_BETA, 0);
    random_ticks(20);
    drain();
    write_cfg(REG_FULLSCALE, 0);
    write_cfg(REG_BETA, 3950);
    write_cfg(REG_RNOM, 20'hFFFFF);
    write_cfg(REG_T0, 16'hFFFF);
    random_ticks(20);
    drain();

    // intervals, including a drop below the current count
    write_cfg(REG_FULLSCALE, 4095);
    write_cfg(REG_VREF, 3300);
    write_cfg(REG_RPULL, 10000);
    write_cfg(REG_RNOM, 10000);
    write_cfg(REG_T0, 29815);
    write_cfg(REG_INTERVAL, 16'hFFFF);
    random_ticks(5);
    drain();
    write_cfg(REG_INTERVAL, 2);
    random_ticks(200);
    drain();
    write_cfg(REG_INTERVAL, 3);
    random_ticks(150);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_cfg(REG_INTERVAL, 20'($urandom_range(1, 4)));
      write_cfg(REG_FULLSCALE, 20'($urandom_range(255, 65535)));
      write_cfg(REG_VREF, 20'($urandom_range(1000, 5000)));
      write_cfg(REG_RPULL, 20'($urandom_range(100, 1000000)));
      write_cfg(REG_RNOM, 20'($urandom_range(100, 1000000)));
      write_cfg(REG_BETA, 20'($urandom_range(1000, 10000)));
      write_cfg(REG_T0, 20'($urandom_range(20000, 40000)));
      random_ticks(200);
      drain();
    end

    write_cfg(REG_INTERVAL, 1);
    calm = 1;
    random_ticks(130);
    drain();

    $display("Sent %0d ticks, checked %0d results over several register settings.",
             ticks_sent, board.results_seen);
    if (board.mismatches == 0 && board.exp_adc.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
